// ----- hw/rtl/ffal_pkg.sv -----
// Shared types and constants of the first-fit free-list allocator.
// Used by ffal_store and first_fit_free_list_allocator_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffal_pkg;

    localparam int ADDR_W     = 16;
    localparam int NEED_W     = 13;
    localparam int ROUND_MASK = 'hF;
    localparam int DATA_LIMIT = 'hFFFF >> 4;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic size_we;
        logic next_we;
    } t_store_we;

endpackage

`default_nettype wire

// ----- hw/rtl/ffal_store.sv -----
// Block size and free-link memories of the allocator, one read port each.
// Depends on ffal_pkg for the write-enable group.
`timescale 1ns / 1ps
`default_nettype none

module ffal_store
    import ffal_pkg::*;
#(
    parameter int GRAN = 4096,
    parameter int GW   = 13,
    parameter int AW   = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [GW-1:0] o_rd_size,
    output logic      [GW-1:0] o_rd_next,
    input  wire t_store_we     i_we,
    input  wire logic [AW-1:0] i_size_addr,
    input  wire logic [GW-1:0] i_size_data,
    input  wire logic [AW-1:0] i_next_addr,
    input  wire logic [GW-1:0] i_next_data
);

    logic [GW-1:0] size_mem [GRAN];
    logic [GW-1:0] next_mem [GRAN];
    logic [GW-1:0] r_size_q;
    logic [GW-1:0] r_next_q;
    logic          r_size0_wr;
    logic          r_next0_wr;
    logic          r_size_dflt;
    logic          r_next_dflt;

    always_ff @(posedge i_clk) begin
        if (i_we.size_we) begin
            size_mem[i_size_addr] <= i_size_data;
        end
        if (i_we.next_we) begin
            next_mem[i_next_addr] <= i_next_data;
        end
        if (i_rd_en) begin
            r_size_q <= size_mem[i_rd_addr];
            r_next_q <= next_mem[i_rd_addr];
        end
    end

    // Entry 0 holds the whole heap after reset until it is first written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size0_wr  <= 1'b0;
            r_next0_wr  <= 1'b0;
            r_size_dflt <= 1'b0;
            r_next_dflt <= 1'b0;
        end else begin
            if (i_we.size_we && i_size_addr == '0) begin
                r_size0_wr <= 1'b1;
            end
            if (i_we.next_we && i_next_addr == '0) begin
                r_next0_wr <= 1'b1;
            end
            if (i_rd_en) begin
                r_size_dflt <= (i_rd_addr == '0) && !r_size0_wr;
                r_next_dflt <= (i_rd_addr == '0) && !r_next0_wr;
            end
        end
    end

    assign o_rd_size = r_size_dflt ? GW'(GRAN) : r_size_q;
    assign o_rd_next = r_next_dflt ? GW'(GRAN) : r_next_q;

endmodule

`default_nettype wire

// ----- hw/rtl/first_fit_free_list_allocator_unit.sv -----
// First-fit heap allocator with coalescing; top level and request sequencer.
// Depends on ffal_pkg and ffal_store.
//
// The heap is managed in 16-byte granules, each block starting with a one-granule
// header. An allocate walks the address-ordered free list and takes the first block
// that fits, splitting off the remainder; a free reinserts the block in order and
// merges it with touching neighbors. One request is handled at a time. Each visited
// free-list node costs one read of the size and link memories, whose read data is
// registered. The next request is taken while the previous result still waits on
// the output register.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_free_list_allocator_unit
    import ffal_pkg::*;
#(
    parameter int HEAP_BYTES = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // request_size[15:0], data_address[31:16]
    input  wire logic        s_axis_tuser,  // func[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // result_address[15:0]
    output logic             m_axis_tuser   // success[0]
);

    localparam int GRAN = HEAP_BYTES / 16;
    localparam int GW   = $clog2(GRAN + 1);
    localparam int AW   = $clog2(GRAN);
    localparam int SW   = $clog2(GRAN + 2);
    localparam int XW   = (GW > 14 ? GW : 14) + 4;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_DEC  = 13'b0000000000010,
        S_ACHK = 13'b0000000000100,
        S_AWT  = 13'b0000000001000,
        S_ASPL = 13'b0000000010000,
        S_FRD  = 13'b0000000100000,
        S_FWT  = 13'b0000001000000,
        S_FLNK = 13'b0000010000000,
        S_RG   = 13'b0000100000000,
        S_RGW  = 13'b0001000000000,
        S_RNW  = 13'b0010000000000,
        S_JP   = 13'b0100000000000,
        S_RESP = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic [GW-1:0]     r_head, n_head;
    logic [GW-1:0]     r_cur, n_cur;
    logic [GW-1:0]     r_prev, n_prev;
    logic [GW-1:0]     r_g, n_g;
    logic [GW-1:0]     r_nx, n_nx;
    logic [GW-1:0]     r_szg, n_szg;
    logic [GW-1:0]     r_szp, n_szp;
    logic [GW-1:0]     r_nextg, n_nextg;
    logic [SW-1:0]     r_steps, n_steps;
    logic [NEED_W-1:0] r_need, n_need;
    logic              r_func, n_func;
    logic [15:0]       r_daddr, n_daddr;
    logic              r_join_nx, n_join_nx;
    logic              r_join_prev, n_join_prev;
    logic [15:0]       r_pend_addr, n_pend_addr;
    logic              r_pend_ok, n_pend_ok;
    logic              r_ovalid, n_ovalid;
    logic [15:0]       r_oaddr, n_oaddr;
    logic              r_ook, n_ook;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [GW-1:0]     rd_size;
    logic [GW-1:0]     rd_next;
    t_store_we         we;
    logic [AW-1:0]     w_size_addr;
    logic [GW-1:0]     w_size_data;
    logic [AW-1:0]     w_next_addr;
    logic [GW-1:0]     w_next_data;

    logic              s_fire;
    logic [XW-1:0]     g_w;
    logic [XW-1:0]     sum_w;
    logic [XW-1:0]     rest_w;
    logic              fit;
    logic              brk;

    ffal_store #(
        .GRAN(GRAN),
        .GW  (GW),
        .AW  (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_size  (rd_size),
        .o_rd_next  (rd_next),
        .i_we       (we),
        .i_size_addr(w_size_addr),
        .i_size_data(w_size_data),
        .i_next_addr(w_next_addr),
        .i_next_data(w_next_data)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_oaddr;
    assign m_axis_tuser  = r_ook;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_g         = r_g;
        n_nx        = r_nx;
        n_szg       = r_szg;
        n_szp       = r_szp;
        n_nextg     = r_nextg;
        n_steps     = r_steps;
        n_need      = r_need;
        n_func      = r_func;
        n_daddr     = r_daddr;
        n_join_nx   = r_join_nx;
        n_join_prev = r_join_prev;
        n_pend_addr = r_pend_addr;
        n_pend_ok   = r_pend_ok;
        n_ovalid    = r_ovalid && !m_axis_tready;
        n_oaddr     = r_oaddr;
        n_ook       = r_ook;
        rd_en       = 1'b0;
        rd_addr     = '0;
        we          = '0;
        w_size_addr = '0;
        w_size_data = '0;
        w_next_addr = '0;
        w_next_data = '0;
        g_w         = XW'(r_daddr[15:4]) - XW'(1);
        sum_w       = '0;
        rest_w      = XW'(r_cur) + XW'(r_need);
        fit         = (XW'(rd_size) >= XW'(r_need)) && (XW'(r_cur) < XW'(DATA_LIMIT))
                      && ((XW'(rd_size) == XW'(r_need)) || (rest_w < XW'(GRAN)));
        brk         = (XW'(rd_next) >= XW'(GRAN)) || (rd_next >= r_g)
                      || (XW'(r_steps) >= XW'(GRAN));

        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_func      = s_axis_tuser;
                    n_daddr     = s_axis_tdata[31:16];
                    n_need      = NEED_W'((({1'b0, s_axis_tdata[15:0]} + 17'(ROUND_MASK)) >> 4)
                                  + 17'd1);
                    n_cur       = r_head;
                    n_prev      = GW'(GRAN);
                    n_steps     = '0;
                    n_pend_addr = '0;
                    n_pend_ok   = 1'b0;
                    n_state     = (s_axis_tuser == FUNC_ALLOC) ? S_ACHK : S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_RESP;
                if (r_daddr == '0) begin
                    n_pend_ok = 1'b1;
                end else if (r_daddr[15:4] == '0 || g_w >= XW'(GRAN)) begin
                    n_pend_ok = 1'b0;
                end else if (XW'(r_head) >= XW'(GRAN)) begin
                    we.next_we  = 1'b1;
                    w_next_addr = AW'(g_w);
                    w_next_data = GW'(GRAN);
                    n_head      = GW'(g_w);
                    n_pend_ok   = 1'b1;
                end else if (GW'(g_w) == r_head) begin
                    n_pend_ok = 1'b0;
                end else if (GW'(g_w) < r_head) begin
                    we.next_we  = 1'b1;
                    w_next_addr = AW'(g_w);
                    w_next_data = r_head;
                    n_nextg     = r_head;
                    n_nx        = r_head;
                    n_head      = GW'(g_w);
                    n_g         = GW'(g_w);
                    n_join_nx   = 1'b1;
                    n_join_prev = 1'b0;
                    n_state     = S_RG;
                end else begin
                    n_g     = GW'(g_w);
                    n_prev  = r_head;
                    n_steps = '0;
                    n_state = S_FRD;
                end
            end
            S_ACHK: begin
                if (XW'(r_cur) >= XW'(GRAN) || XW'(r_steps) > XW'(GRAN)) begin
                    n_pend_ok = 1'b0;
                    n_state   = S_RESP;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_cur);
                    n_state = S_AWT;
                end
            end
            S_AWT: begin
                if (fit) begin
                    n_pend_addr = 16'((XW'(r_cur) + XW'(1)) << 4);
                    if (XW'(rd_size) == XW'(r_need)) begin
                        if (XW'(r_prev) >= XW'(GRAN)) begin
                            n_head = rd_next;
                        end else begin
                            we.next_we  = 1'b1;
                            w_next_addr = AW'(r_prev);
                            w_next_data = rd_next;
                        end
                        n_pend_ok = 1'b1;
                        n_state   = S_RESP;
                    end else begin
                        we.size_we  = 1'b1;
                        we.next_we  = 1'b1;
                        w_size_addr = AW'(rest_w);
                        w_size_data = GW'(XW'(rd_size) - XW'(r_need));
                        w_next_addr = AW'(rest_w);
                        w_next_data = rd_next;
                        n_nx        = GW'(rest_w);
                        n_state     = S_ASPL;
                    end
                end else begin
                    n_prev  = r_cur;
                    n_cur   = rd_next;
                    n_steps = r_steps + SW'(1);
                    n_state = S_ACHK;
                end
            end
            S_ASPL: begin
                we.size_we  = 1'b1;
                w_size_addr = AW'(r_cur);
                w_size_data = GW'(r_need);
                if (XW'(r_prev) >= XW'(GRAN)) begin
                    n_head = r_nx;
                end else begin
                    we.next_we  = 1'b1;
                    w_next_addr = AW'(r_prev);
                    w_next_data = r_nx;
                end
                n_pend_ok = 1'b1;
                n_state   = S_RESP;
            end
            S_FRD: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_prev);
                n_state = S_FWT;
            end
            S_FWT: begin
                n_szp = rd_size;
                if (!brk) begin
                    n_prev  = rd_next;
                    n_steps = r_steps + SW'(1);
                    n_state = S_FRD;
                end else if (r_prev == r_g || rd_next == r_g) begin
                    n_pend_ok = 1'b0;
                    n_state   = S_RESP;
                end else begin
                    we.next_we  = 1'b1;
                    w_next_addr = AW'(r_g);
                    w_next_data = (XW'(rd_next) < XW'(GRAN)) ? rd_next : GW'(GRAN);
                    n_nextg     = w_next_data;
                    n_nx        = rd_next;
                    n_join_nx   = XW'(rd_next) < XW'(GRAN);
                    n_join_prev = 1'b1;
                    n_state     = S_FLNK;
                end
            end
            S_FLNK: begin
                we.next_we  = 1'b1;
                w_next_addr = AW'(r_prev);
                w_next_data = r_g;
                n_state     = S_RG;
            end
            S_RG: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_g);
                n_state = S_RGW;
            end
            S_RGW: begin
                n_szg = rd_size;
                if (r_join_nx) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_nx);
                    n_state = S_RNW;
                end else if (r_join_prev) begin
                    n_state = S_JP;
                end else begin
                    n_pend_ok = 1'b1;
                    n_state   = S_RESP;
                end
            end
            S_RNW: begin
                if (XW'(r_g) + XW'(r_szg) == XW'(r_nx)) begin
                    sum_w       = XW'(r_szg) + XW'(rd_size);
                    if (sum_w > XW'(GRAN)) begin
                        sum_w = XW'(GRAN);
                    end
                    we.size_we  = 1'b1;
                    we.next_we  = 1'b1;
                    w_size_addr = AW'(r_g);
                    w_size_data = GW'(sum_w);
                    w_next_addr = AW'(r_g);
                    w_next_data = rd_next;
                    n_szg       = GW'(sum_w);
                    n_nextg     = rd_next;
                end
                if (r_join_prev) begin
                    n_state = S_JP;
                end else begin
                    n_pend_ok = 1'b1;
                    n_state   = S_RESP;
                end
            end
            S_JP: begin
                if (XW'(r_prev) + XW'(r_szp) == XW'(r_g)) begin
                    sum_w       = XW'(r_szp) + XW'(r_szg);
                    if (sum_w > XW'(GRAN)) begin
                        sum_w = XW'(GRAN);
                    end
                    we.size_we  = 1'b1;
                    we.next_we  = 1'b1;
                    w_size_addr = AW'(r_prev);
                    w_size_data = GW'(sum_w);
                    w_next_addr = AW'(r_prev);
                    w_next_data = r_nextg;
                end
                n_pend_ok = 1'b1;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_oaddr  = r_pend_addr;
                    n_ook    = r_pend_ok;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_g         <= n_g;
        r_nx        <= n_nx;
        r_szg       <= n_szg;
        r_szp       <= n_szp;
        r_nextg     <= n_nextg;
        r_steps     <= n_steps;
        r_need      <= n_need;
        r_func      <= n_func;
        r_daddr     <= n_daddr;
        r_join_nx   <= n_join_nx;
        r_join_prev <= n_join_prev;
        r_pend_addr <= n_pend_addr;
        r_pend_ok   <= n_pend_ok;
        r_oaddr     <= n_oaddr;
        r_ook       <= n_ook;
    end

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_head) <= XW'(GRAN))
        else $error("free list head outside heap");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> r_state != S_IDLE)
        else $error("accepted beat did not start a request");

    a_alloc_no_free_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRD || r_state == S_JP) |-> r_func == FUNC_FREE)
        else $error("free-list insertion during an allocate");

    a_fail_has_no_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && !r_pend_ok) |-> r_pend_addr == '0)
        else $error("failed request carries an address");

    a_write_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we.size_we |-> XW'(w_size_addr) < XW'(GRAN))
        else $error("size write outside heap");

endmodule

`default_nettype wire
